// ===== rtl/core/ugn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugn_pkg
// shared constants, types and helper functions of the upwind gradient stencil
// ----------------------------------------------------------------------------
package ugn_pkg;

   localparam int MAX_COLS   = 1024;
   localparam int MAX_ROWS   = 1024;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int SIZE_W     = 11;
   localparam int DATA_W     = 32;
   localparam int INV_W      = 24;
   localparam int DIR_W      = 2;
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int PROD_W     = DATA_W + INV_W;
   localparam int TERM_W     = PROD_W - 16;
   localparam int SQ_W       = 2 * DATA_W;
   localparam int REM_W      = DATA_W + 2;
   localparam int SQRT_STEPS = 2;
   localparam int SQRT_STAGES = DATA_W / SQRT_STEPS;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 3'd4;

   // speed sign codes
   localparam logic [1:0] SIGN_ZERO = 2'b00;
   localparam logic [1:0] SIGN_POS  = 2'b01;
   localparam logic [1:0] SIGN_NEG  = 2'b11;

   typedef struct packed {
      logic              valid;
      logic              interior;
      logic              last;
      logic [1:0]        csign;
      logic [DATA_W-1:0] up;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] mid;
      logic [DATA_W-1:0] right;
      logic [DATA_W-1:0] down;
   } win_type;

   typedef struct packed {
      logic            valid;
      logic            last;
      logic            sat;
      logic [SQ_W-1:0] sum;
   } sum_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [DATA_W-1:0] norm;
   } res_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [DATA_W-1:0] root;
   } sqrt_state_type;

   // max(a, b, 0) of two signed differences
   function automatic logic [DATA_W-1:0] max_pos(input logic signed [DATA_W:0] a,
                                                 input logic signed [DATA_W:0] b);
      logic signed [DATA_W:0] m;
      begin
         m = (a > b) ? a : b;
         max_pos = m[DATA_W] ? '0 : m[DATA_W-1:0];
      end
   endfunction

   // one digit of the restoring square root
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type st,
                                                input logic [1:0] pair);
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] t;
      sqrt_state_type   nx;
      begin
         r = {st.rem[DATA_W-1:0], pair};
         t = {st.root, 2'b01};
         if (r >= t) begin
            nx.rem  = r - t;
            nx.root = {st.root[DATA_W-2:0], 1'b1};
         end else begin
            nx.rem  = r;
            nx.root = {st.root[DATA_W-2:0], 1'b0};
         end
         sqrt_step = nx;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ugn_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugn_front
// raster counters, line buffers and the 3x3 window
// ----------------------------------------------------------------------------
module ugn_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          accept,
   input  wire logic [ugn_pkg::DATA_W-1:0]    level_value,
   input  wire logic [ugn_pkg::DATA_W-1:0]    speed_value,
   input  wire logic [ugn_pkg::SIZE_W-1:0]    cols_cfg,
   input  wire logic [ugn_pkg::SIZE_W-1:0]    rows_cfg,
   output ugn_pkg::win_type                   win
);

   localparam int DW = ugn_pkg::DATA_W;
   localparam int SW = ugn_pkg::SIZE_W;
   localparam int CW = ugn_pkg::COL_W;
   localparam int RW = ugn_pkg::ROW_W;

   logic [2*DW-1:0] lvl_mem [ugn_pkg::MAX_COLS];
   logic [1:0]      sign_mem [ugn_pkg::MAX_COLS];

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [SW-1:0] cols_eff, rows_eff;
   logic [CW-1:0] c_cur;
   logic [RW-1:0] r_cur;
   logic          col_last, row_last;
   logic [1:0]    new_sign;

   // stage 1
   logic          s1_valid_ff;
   logic          s1_int_ff, s1_last_ff;
   logic [CW-1:0] s1_col_ff;
   logic [DW-1:0] s1_x_ff;
   logic [2*DW-1:0] rd_lvl_ff;
   logic [1:0]    rd_sign_ff;

   // stage 2: window
   logic [DW-1:0] win_ff [9];
   logic [1:0]    sign_delay_ff;
   logic          s2_valid_ff, s2_int_ff, s2_last_ff;
   logic [1:0]    s2_csign_ff;

   always_comb begin
      if (cols_cfg < SW'(3))                         cols_eff = SW'(3);
      else if (cols_cfg > SW'(ugn_pkg::MAX_COLS))    cols_eff = SW'(ugn_pkg::MAX_COLS);
      else                                           cols_eff = cols_cfg;
      if (rows_cfg < SW'(3))                         rows_eff = SW'(3);
      else if (rows_cfg > SW'(ugn_pkg::MAX_ROWS))    rows_eff = SW'(ugn_pkg::MAX_ROWS);
      else                                           rows_eff = rows_cfg;
      c_cur = (SW'(col_ff) < cols_eff) ? col_ff : CW'(cols_eff - SW'(1));
      r_cur = (SW'(row_ff) < rows_eff) ? row_ff : RW'(rows_eff - SW'(1));
      col_last = (SW'(c_cur) == cols_eff - SW'(1));
      row_last = (SW'(r_cur) == rows_eff - SW'(1));
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : r_cur + RW'(1);
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
      if (speed_value == '0)         new_sign = ugn_pkg::SIGN_ZERO;
      else if (speed_value[DW-1])    new_sign = ugn_pkg::SIGN_NEG;
      else                           new_sign = ugn_pkg::SIGN_POS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers: entry holds {row r-2, row r-1}, written back as the item leaves stage 1
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_lvl_ff      <= lvl_mem[c_cur];
         rd_sign_ff     <= sign_mem[c_cur];
         sign_mem[c_cur] <= new_sign;
      end
      if (en && s1_valid_ff) begin
         lvl_mem[s1_col_ff] <= {rd_lvl_ff[DW-1:0], s1_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_x_ff    <= level_value;
         s1_col_ff  <= c_cur;
         s1_int_ff  <= (r_cur >= RW'(2)) && (c_cur >= CW'(2));
         s1_last_ff <= row_last && col_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         sign_delay_ff <= ugn_pkg::SIGN_ZERO;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k*3]   <= win_ff[k*3+1];
               win_ff[k*3+1] <= win_ff[k*3+2];
            end
            win_ff[2]     <= rd_lvl_ff[2*DW-1:DW];
            win_ff[5]     <= rd_lvl_ff[DW-1:0];
            win_ff[8]     <= s1_x_ff;
            sign_delay_ff <= rd_sign_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         s2_int_ff   <= s1_int_ff;
         s2_last_ff  <= s1_last_ff;
         s2_csign_ff <= sign_delay_ff;
      end
   end

   assign win.valid    = s2_valid_ff;
   assign win.interior = s2_int_ff;
   assign win.last     = s2_last_ff;
   assign win.csign    = s2_csign_ff;
   assign win.up       = win_ff[1];
   assign win.left     = win_ff[3];
   assign win.mid      = win_ff[4];
   assign win.right    = win_ff[5];
   assign win.down     = win_ff[7];

endmodule
`default_nettype wire

// ===== rtl/core/ugn_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugn_arith
// upwind differences, scaling, squares and sum of squares
// ----------------------------------------------------------------------------
module ugn_arith (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire ugn_pkg::win_type              win,
   input  wire logic [ugn_pkg::DIR_W-1:0]     direction,
   input  wire logic [ugn_pkg::INV_W-1:0]     inv_dx,
   input  wire logic [ugn_pkg::INV_W-1:0]     inv_dy,
   output ugn_pkg::sum_type                   sum_out
);

   localparam int DW = ugn_pkg::DATA_W;
   localparam int PW = ugn_pkg::PROD_W;
   localparam int TW = ugn_pkg::TERM_W;
   localparam int QW = ugn_pkg::SQ_W;

   logic [4:0] v_ff, l_ff;

   logic                  pos;
   logic signed [DW:0]    ext_up, ext_left, ext_mid, ext_right, ext_down;
   logic signed [DW:0]    ax0_ff, ax1_ff, ay0_ff, ay1_ff;
   logic [DW-1:0]         mx_ff, my_ff;
   logic [PW-1:0]         px, py;
   logic [TW-1:0]         tx_ff, ty_ff;
   logic                  sat_d_ff, sat_e_ff;
   logic [QW-1:0]         sx_ff, sy_ff;
   logic [QW:0]           sum_full;
   logic [QW-1:0]         sum_ff;

   always_comb begin
      pos = ((win.csign == ugn_pkg::SIGN_POS) && !direction[1] && direction[0]) ||
            ((win.csign == ugn_pkg::SIGN_NEG) && direction[1]);
      ext_up    = {win.up[DW-1], win.up};
      ext_left  = {win.left[DW-1], win.left};
      ext_mid   = {win.mid[DW-1], win.mid};
      ext_right = {win.right[DW-1], win.right};
      ext_down  = {win.down[DW-1], win.down};
      px = PW'(mx_ff) * PW'(inv_dx);
      py = PW'(my_ff) * PW'(inv_dy);
      sum_full = {1'b0, sx_ff} + {1'b0, sy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], win.valid && win.interior};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff <= {l_ff[3:0], win.last};
         // upwind side follows the sign of speed times direction
         if (pos) begin
            ax0_ff <= ext_down - ext_mid;
            ax1_ff <= ext_up - ext_mid;
            ay0_ff <= ext_right - ext_mid;
            ay1_ff <= ext_left - ext_mid;
         end else begin
            ax0_ff <= ext_mid - ext_down;
            ax1_ff <= ext_mid - ext_up;
            ay0_ff <= ext_mid - ext_right;
            ay1_ff <= ext_mid - ext_left;
         end
         mx_ff    <= ugn_pkg::max_pos(ax0_ff, ax1_ff);
         my_ff    <= ugn_pkg::max_pos(ay0_ff, ay1_ff);
         tx_ff    <= px[PW-1:16];
         ty_ff    <= py[PW-1:16];
         sat_d_ff <= (|tx_ff[TW-1:DW]) || (|ty_ff[TW-1:DW]);
         sx_ff    <= QW'(tx_ff[DW-1:0]) * QW'(tx_ff[DW-1:0]);
         sy_ff    <= QW'(ty_ff[DW-1:0]) * QW'(ty_ff[DW-1:0]);
         sat_e_ff <= sat_d_ff || sum_full[QW];
         sum_ff   <= sum_full[QW-1:0];
      end
   end

   assign sum_out.valid = v_ff[4];
   assign sum_out.last  = l_ff[4];
   assign sum_out.sat   = sat_e_ff;
   assign sum_out.sum   = sum_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ugn_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugn_sqrt
// pipelined integer square root, two result bits per stage, saturating
// ----------------------------------------------------------------------------
module ugn_sqrt (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire ugn_pkg::sum_type sum_in,
   output ugn_pkg::res_type      res
);

   localparam int NS = ugn_pkg::SQRT_STAGES;
   localparam int QW = ugn_pkg::SQ_W;

   logic                    v_ff   [NS];
   logic                    l_ff   [NS];
   logic                    sat_ff [NS];
   logic [QW-1:0]           rad_ff [NS];
   ugn_pkg::sqrt_state_type st_ff  [NS];

   genvar g;
   generate
      for (g = 0; g < NS; g++) begin : g_stage
         logic                    v_prev, l_prev, sat_prev;
         logic [QW-1:0]           rad_prev;
         ugn_pkg::sqrt_state_type st_prev, st_next;

         if (g == 0) begin : g_first
            always_comb begin
               v_prev   = sum_in.valid;
               l_prev   = sum_in.last;
               sat_prev = sum_in.sat;
               rad_prev = sum_in.sum;
               st_prev  = '0;
            end
         end else begin : g_rest
            always_comb begin
               v_prev   = v_ff[g-1];
               l_prev   = l_ff[g-1];
               sat_prev = sat_ff[g-1];
               rad_prev = rad_ff[g-1];
               st_prev  = st_ff[g-1];
            end
         end

         // one root bit per radicand bit pair, top pairs first
         always_comb begin
            st_next = st_prev;
            for (int s = 0; s < ugn_pkg::SQRT_STEPS; s++) begin
               st_next = ugn_pkg::sqrt_step(st_next, rad_prev[QW-1-2*s -: 2]);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (en) begin
               v_ff[g] <= v_prev;
            end
            if (en) begin
               l_ff[g]   <= l_prev;
               sat_ff[g] <= sat_prev;
               rad_ff[g] <= rad_prev << (2 * ugn_pkg::SQRT_STEPS);
               st_ff[g]  <= st_next;
            end
         end
      end
   endgenerate

   assign res.valid = v_ff[NS-1];
   assign res.last  = l_ff[NS-1];
   assign res.norm  = sat_ff[NS-1] ? '1 : st_ff[NS-1].root;

endmodule
`default_nettype wire

// ===== rtl/core/upwind_gradient_norm_stencil.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upwind_gradient_norm_stencil
// upwind level-set gradient magnitude over a streamed grid with ghost border
// ----------------------------------------------------------------------------
// throughput: one item per cycle while req_stall is low; every stage is a single register step
// border samples advance the window but give no result
// req_stall rises only when the output register and the skid stage are both full
// reset (synchronous) clears counters, window, valid bits and config to defaults;
// line buffers are not cleared; entries read before being written only reach border windows
module upwind_gradient_norm_stencil (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input items
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [ugn_pkg::DATA_W-1:0]       req_level_value,
   input  wire logic [ugn_pkg::DATA_W-1:0]       req_speed_value,
   // result items
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [ugn_pkg::DATA_W-1:0]       rsp_gradient_norm,
   output      logic                             rsp_last_of_grid,
   // configuration
   input  wire logic                             csr_write_enable,
   input  wire logic [ugn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ugn_pkg::CSR_W-1:0]        csr_write_data
);

   localparam int DW = ugn_pkg::DATA_W;

   // configuration registers
   logic [ugn_pkg::DIR_W-1:0]  direction_ff;
   logic [ugn_pkg::INV_W-1:0]  inv_dx_ff, inv_dy_ff;
   logic [ugn_pkg::SIZE_W-1:0] cols_ff, rows_ff;

   // pipeline advance: whole pipe moves unless the skid stage is holding an item
   logic en;
   logic accept;

   ugn_pkg::win_type win;
   ugn_pkg::sum_type sums;
   ugn_pkg::res_type res;

   // output register plus one skid entry
   logic          out_valid_ff;
   logic [DW-1:0] out_norm_ff;
   logic          out_last_ff;
   logic          skid_valid_ff;
   logic [DW-1:0] skid_norm_ff;
   logic          skid_last_ff;

   assign en     = !skid_valid_ff;
   assign accept = req_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= ugn_pkg::DIR_W'(1);
         inv_dx_ff    <= ugn_pkg::INV_W'(65536);
         inv_dy_ff    <= ugn_pkg::INV_W'(65536);
         cols_ff      <= ugn_pkg::SIZE_W'(1024);
         rows_ff      <= ugn_pkg::SIZE_W'(1024);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ugn_pkg::CSR_DIRECTION: direction_ff <= csr_write_data[ugn_pkg::DIR_W-1:0];
            ugn_pkg::CSR_INV_DX:    inv_dx_ff    <= csr_write_data[ugn_pkg::INV_W-1:0];
            ugn_pkg::CSR_INV_DY:    inv_dy_ff    <= csr_write_data[ugn_pkg::INV_W-1:0];
            ugn_pkg::CSR_COLS:      cols_ff      <= csr_write_data[ugn_pkg::SIZE_W-1:0];
            ugn_pkg::CSR_ROWS:      rows_ff      <= csr_write_data[ugn_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // counters, line buffers and the 3x3 window
   ugn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .accept      (accept),
      .level_value (req_level_value),
      .speed_value (req_speed_value),
      .cols_cfg    (cols_ff),
      .rows_cfg    (rows_ff),
      .win         (win)
   );

   // upwind selection, scaling and sum of squares
   ugn_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .win       (win),
      .direction (direction_ff),
      .inv_dx    (inv_dx_ff),
      .inv_dy    (inv_dy_ff),
      .sum_out   (sums)
   );

   // square root, 16 stages
   ugn_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .sum_in (sums),
      .res    (res)
   );

   // output side: a result that meets a stalled output parks in the skid entry, and the pipe holds until it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (res.valid) begin
         if (out_valid_ff && rsp_stall) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_norm_ff <= skid_norm_ff;
            out_last_ff <= skid_last_ff;
         end
      end else if (res.valid) begin
         if (out_valid_ff && rsp_stall) begin
            skid_norm_ff <= res.norm;
            skid_last_ff <= res.last;
         end else begin
            out_norm_ff <= res.norm;
            out_last_ff <= res.last;
         end
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_gradient_norm = out_norm_ff;
   assign rsp_last_of_grid  = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ugn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ugn_checker
// port-level checks of the stencil, bound to the top level
// ----------------------------------------------------------------------------
module ugn_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [ugn_pkg::DATA_W-1:0] rsp_gradient_norm
);

   // reset empties the output side and opens the input
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   // input back-pressure only follows a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient_norm))
      else $error("stalled result changed");

endmodule

bind upwind_gradient_norm_stencil ugn_checker u_ugn_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_gradient_norm (rsp_gradient_norm)
);
`default_nettype wire
